// ----- rtl/mi_pkg.sv -----
// Shared definitions for the modular inverse core.
// Holds the default word width and the sequencer state codes; no dependencies.
package mi_pkg;

   localparam int WIDTH_DEFAULT = 32;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_ALIGN  = 8'b0000_0100,
      ST_DIVIDE = 8'b0000_1000,
      ST_UPDATE = 8'b0001_0000,
      ST_REDUCE = 8'b0010_0000,
      ST_NEGATE = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } mi_state_type;

endpackage

// ----- rtl/mi_if.sv -----
// Valid/ready channel interfaces for the modular inverse core.
// Request carries value and modulus, response carries inverse and gcd; uses mi_pkg.
interface mi_req_if #(parameter int WIDTH = mi_pkg::WIDTH_DEFAULT);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value;
   logic [WIDTH-1:0] modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mi_rsp_if #(parameter int WIDTH = mi_pkg::WIDTH_DEFAULT);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] inverse;
   logic [WIDTH-1:0] common_divisor;

   modport source (output valid, output inverse, output common_divisor, input ready);
   modport sink   (input valid, input inverse, input common_divisor, output ready);
endinterface

// ----- rtl/modular_inverse_core.sv -----
// Modular inverse by the extended Euclidean algorithm, one item at a time.
// Depends on mi_pkg, the channel interfaces in mi_if and the mi_alu unit.
//
// Each request (value, modulus) returns one response: the Bezout coefficient of value
// reduced into 0..modulus-1, and gcd(value, modulus); the coefficient is the inverse
// exactly when common_divisor is 1. A zero modulus gives gcd = value and inverse 0.
// Every Euclid step is a shift-and-subtract division on the single shared subtractor:
// the divisor is aligned one bit a cycle, then one quotient bit a cycle is produced
// while q * s is accumulated alongside. Over an item the alignment shifts of all steps
// (each the quotient's bit length less one, or zero) telescope to at most WIDTH. The
// request side is ready only while idle; a finished result waits in the output
// register and the next request can be taken meanwhile.
module modular_inverse_core #(
   parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   mi_req_if.sink   req_bus,
   mi_rsp_if.source rsp_bus
);
   import mi_pkg::*;

   localparam int STEP_LIMIT = 2 * WIDTH + 4;
   localparam int STEP_BITS  = $clog2(STEP_LIMIT + 1);
   localparam int CNT_BITS   = $clog2(WIDTH);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(STEP_LIMIT);

   mi_state_type state_ff, state_in;

   logic [WIDTH-1:0]     r_prev_ff, r_prev_in;
   logic [WIDTH-1:0]     r_cur_ff, r_cur_in;
   logic [WIDTH-1:0]     s_prev_ff, s_prev_in;
   logic [WIDTH-1:0]     s_cur_ff, s_cur_in;
   logic                 neg_prev_ff, neg_prev_in;
   logic                 neg_cur_ff, neg_cur_in;
   logic [WIDTH-1:0]     mod_ff, mod_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     dsh_ff, dsh_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     res_ff, res_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_inverse_ff, rsp_inverse_in;
   logic [WIDTH-1:0] rsp_gcd_ff, rsp_gcd_in;

   logic [WIDTH-1:0] alu_x, alu_y, alu_diff;
   logic             alu_ge;
   logic             req_xfer, out_free;

   mi_alu #(.WIDTH(WIDTH)) u_alu (
      .x    (alu_x),
      .y    (alu_y),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign req_xfer               = req_bus.valid && req_bus.ready;
   assign out_free               = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.inverse        = rsp_inverse_ff;
   assign rsp_bus.common_divisor = rsp_gcd_ff;

   // operand selection for the shared subtractor
   always_comb begin
      case (state_ff)
         ST_ALIGN: begin
            alu_x = rem_ff;
            alu_y = {dsh_ff[WIDTH-2:0], 1'b0};
         end
         ST_DIVIDE: begin
            alu_x = rem_ff;
            alu_y = dsh_ff;
         end
         ST_REDUCE: begin
            alu_x = s_prev_ff;
            alu_y = mod_ff;
         end
         ST_NEGATE: begin
            alu_x = mod_ff;
            alu_y = res_ff;
         end
         default: begin
            alu_x = rem_ff;
            alu_y = dsh_ff;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      r_prev_in      = r_prev_ff;
      r_cur_in       = r_cur_ff;
      s_prev_in      = s_prev_ff;
      s_cur_in       = s_cur_ff;
      neg_prev_in    = neg_prev_ff;
      neg_cur_in     = neg_cur_ff;
      mod_in         = mod_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      acc_in         = acc_ff;
      res_in         = res_ff;
      cnt_in         = cnt_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_gcd_in     = rsp_gcd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               r_prev_in   = req_bus.value;
               r_cur_in    = req_bus.modulus;
               mod_in      = req_bus.modulus;
               s_prev_in   = WIDTH'(1);
               s_cur_in    = '0;
               neg_prev_in = 1'b0;
               neg_cur_in  = 1'b1;
               step_in     = '0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (r_cur_ff == '0 || step_ff == STEP_LAST) begin
               if (mod_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end else begin
               rem_in   = r_prev_ff;
               dsh_in   = r_cur_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // grow the divisor while its double still fits under the dividend
            if (!dsh_ff[WIDTH-1] && alu_ge) begin
               dsh_in = {dsh_ff[WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff + CNT_BITS'(1);
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (alu_ge) begin
               rem_in = alu_diff;
            end
            // quotient bits arrive MSB first, so shift-and-add builds q * s_cur
            acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (alu_ge ? s_cur_ff : '0);
            dsh_in = {1'b0, dsh_ff[WIDTH-1:1]};
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_UPDATE: begin
            r_prev_in   = r_cur_ff;
            r_cur_in    = rem_ff;
            s_prev_in   = s_cur_ff;
            s_cur_in    = s_prev_ff + acc_ff;
            neg_prev_in = neg_cur_ff;
            neg_cur_in  = neg_prev_ff;
            step_in     = step_ff + STEP_BITS'(1);
            state_in    = ST_CHECK;
         end
         ST_REDUCE: begin
            // final magnitude never reaches twice the modulus
            res_in   = alu_ge ? alu_diff : s_prev_ff;
            state_in = ST_NEGATE;
         end
         ST_NEGATE: begin
            if (neg_prev_ff && res_ff != '0) begin
               res_in = alu_diff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_inverse_in = res_ff;
               rsp_gcd_in     = r_prev_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_prev_ff      <= r_prev_in;
      r_cur_ff       <= r_cur_in;
      s_prev_ff      <= s_prev_in;
      s_cur_ff       <= s_cur_in;
      neg_prev_ff    <= neg_prev_in;
      neg_cur_ff     <= neg_cur_in;
      mod_ff         <= mod_in;
      rem_ff         <= rem_in;
      dsh_ff         <= dsh_in;
      acc_ff         <= acc_in;
      res_ff         <= res_in;
      cnt_ff         <= cnt_in;
      step_ff        <= step_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_gcd_ff     <= rsp_gcd_in;
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (rem_ff < r_cur_ff))
      else $error("remainder not below divisor after division");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && mod_ff != '0) |-> (res_ff < mod_ff))
      else $error("inverse not reduced below modulus");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_ALIGN) |-> !req_bus.ready)
      else $error("request accepted while dividing");

endmodule

// ----- rtl/mi_alu.sv -----
// Shared subtract/compare unit of the modular inverse core.
// Gives x - y and the flag x >= y; no dependencies beyond mi_pkg defaults.
module mi_alu #(
   parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);
   logic [WIDTH:0] full;

   assign full = {1'b0, x} - {1'b0, y};
   assign diff = full[WIDTH-1:0];
   assign ge   = ~full[WIDTH];
endmodule
